>>> design/assert_macros.svh
// Assertion helpers for the checker file.
// Both macros sample on the rising edge of clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SKV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/skv_pkg.sv
package skv_pkg;

  // Default sizes
  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths of the request, the result and the register
  localparam int REQ_TYPE_BITS = 2;
  localparam int RD_BITS       = 16;
  localparam int COUNT_BITS    = 5;
  localparam int MISS_BITS     = 16;

  // Request codes; the unused code behaves as a lookup
  localparam logic [REQ_TYPE_BITS-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_DELETE = 2'd2;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic valid;  // cell holds a live entry
    logic load;   // take the new key and value
    logic shift;  // take the neighbor's entry
  } skv_cell_ctl_t;

endpackage

>>> design/skv_req_if.sv
interface skv_req_if import skv_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [REQ_TYPE_BITS-1:0] req_type;
  logic [KEY_BITS-1:0]      key;
  logic [VALUE_BITS-1:0]    value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

>>> design/skv_rsp_if.sv
interface skv_rsp_if import skv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [RD_BITS-1:0]    read_value;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  is_empty;
  logic                  is_full;
  logic                  rejected;

  modport source (output valid, output found, output read_value, output entry_count,
                  output is_empty, output is_full, output rejected, input ready);
  modport sink   (input valid, input found, input read_value, input entry_count,
                  input is_empty, input is_full, input rejected, output ready);
endinterface

>>> design/small_key_value_table.sv
// Flow: an accepted request passes a search state, where every cell compares
//   and the match is registered, then an apply state that commits the update.
// Only one request is taken at a time; a response not yet taken holds the
//   commit, and with it the input, until the sink takes it.
// Reset: rst (synchronous, active high) empties the table, clears the missing
//   value to 0 and drops any pending response; entry contents stay undefined.
module small_key_value_table import skv_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [MISS_BITS-1:0] cfg_data,
  skv_req_if.sink              req,
  skv_rsp_if.source            rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;

  logic [1:0]               state;
  logic [REQ_TYPE_BITS-1:0] op;
  logic [KEY_BITS-1:0]      key_q;
  logic [VALUE_BITS-1:0]    val_q;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [MISS_BITS-1:0]     missing_value;
  logic [CAPACITY-1:0]      match;
  logic [CAPACITY-1:0]      match_q;
  logic [IDX_W-1:0]         pos;
  logic [VALUE_BITS-1:0]    hit_value;
  logic                     hit;
  logic                     full;
  logic                     commit;
  logic                     is_ins;
  logic                     is_del;
  logic                     is_look;
  logic                     do_ins;
  logic                     do_del;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  skv_cell_ctl_t         cell_ctl   [CAPACITY];

  assign req.ready = (state == ST_IDLE);
  assign commit    = (state == ST_APPLY) && (!rsp.valid || rsp.ready);

  // Decode the held request
  assign is_ins  = (op == REQ_INSERT);
  assign is_del  = (op == REQ_DELETE);
  assign is_look = !is_ins && !is_del;
  assign hit     = |match_q;
  assign full    = (count == CNT_W'(CAPACITY));
  assign do_ins  = is_ins && !hit && !full;
  assign do_del  = is_del && hit;

  // Encode the hit position and select its value
  always_comb begin
    pos       = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) begin
        pos       = pos | IDX_W'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  // Count after this request
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Row of cells, each fed by its upper neighbor; the last one feeds back its own entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctl[i].valid = (CNT_W'(i) < count);
    assign cell_ctl[i].load  = commit && do_ins && (CNT_W'(i) == count);
    assign cell_ctl[i].shift = commit && do_del && (IDX_W'(i) >= pos);

    if (i == CAPACITY - 1) begin : g_last
      skv_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .search_key (key_q),
        .new_value  (val_q),
        .next_key   (cell_key[i]),
        .next_value (cell_value[i]),
        .key        (cell_key[i]),
        .value      (cell_value[i]),
        .match      (match[i])
      );
    end else begin : g_mid
      skv_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .search_key (key_q),
        .new_value  (val_q),
        .next_key   (cell_key[i+1]),
        .next_value (cell_value[i+1]),
        .key        (cell_key[i]),
        .value      (cell_value[i]),
        .match      (match[i])
      );
    end
  end

  // Capture the request and the compare result
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op    <= req.req_type;
      key_q <= req.key;
      val_q <= req.value;
    end
    if (state == ST_SEARCH) begin
      match_q <= match;
    end
  end

  // Sequence: accept, compare, commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (commit) begin
            state <= ST_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the missing value register
  always_ff @(posedge clk) begin
    if (rst) begin
      missing_value <= '0;
    end else if (cfg_we) begin
      missing_value <= cfg_data;
    end
  end

  // Response register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.found       <= hit;
      rsp.read_value  <= (is_look && hit) ? RD_BITS'(hit_value)
                                          : RD_BITS'(VALUE_BITS'(missing_value));
      rsp.entry_count <= COUNT_BITS'(count_next);
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == CNT_W'(CAPACITY));
      rsp.rejected    <= is_ins && !hit && full;
    end
  end

endmodule

>>> design/skv_cell.sv
module skv_cell import skv_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  skv_cell_ctl_t         ctl,
  input  logic [KEY_BITS-1:0]   search_key,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  match
);

  // Compare the stored key against the broadcast key
  assign match = ctl.valid && (key == search_key);

  // Load a new entry or pull the neighbor's entry down
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key   <= search_key;
      value <= new_value;
    end else if (ctl.shift) begin
      key   <= next_key;
      value <= next_value;
    end
  end

endmodule

>>> design/skv_checker.sv
`include "assert_macros.svh"

module skv_checker import skv_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  found,
  input logic [RD_BITS-1:0]    read_value,
  input logic [COUNT_BITS-1:0] entry_count,
  input logic                  is_empty,
  input logic                  is_full,
  input logic                  rejected
);

  // A stalled response holds its payload
  `SKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value) && $stable(entry_count) && $stable(found), "response changed while stalled")

  // One request in flight at a time
  `SKV_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

  // A drop only happens on a full table and a new key
  `SKV_ASSERT_NOW(a_reject_full, rsp_valid && rejected, is_full && !found, "reject without full table")

  // Empty means a zero count and never full
  `SKV_ASSERT_NOW(a_empty_count, rsp_valid && is_empty, entry_count == '0 && !is_full, "empty flag disagrees with count")

endmodule

bind small_key_value_table skv_checker u_skv_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .read_value  (rsp.read_value),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty),
  .is_full     (rsp.is_full),
  .rejected    (rsp.rejected)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import skv_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int POOL_SIZE = 20;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_REQUESTS = 185;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 120;
  localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
  localparam logic [MISS_BITS-1:0] DIRECTED_MISS = 16'hC35A;

  typedef struct packed {
    logic [REQ_TYPE_BITS-1:0]  req_type;
    logic [KEY_BITS_DEF-1:0]   key;
    logic [VALUE_BITS_DEF-1:0] value;
  } table_request_t;

  typedef struct packed {
    logic                  found;
    logic [RD_BITS-1:0]    read_value;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  is_empty;
    logic                  is_full;
    logic                  rejected;
  } table_result_t;

  typedef struct {
    table_request_t req;
    bit             typed;
    table_result_t  want;
  } directed_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [MISS_BITS-1:0] cfg_data;

  skv_req_if req_bus ();
  skv_rsp_if rsp_bus ();

  small_key_value_table dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  // Shadow copy of the table
  logic [KEY_BITS_DEF-1:0]   model_keys [CAPACITY];
  logic [VALUE_BITS_DEF-1:0] model_values [CAPACITY];
  int                        model_count = 0;
  logic [MISS_BITS-1:0]      model_missing = '0;

  table_result_t             expected_results [$];
  directed_row_t             directed_rows [$];
  logic [KEY_BITS_DEF-1:0]   key_pool [POOL_SIZE];
  int unsigned               fail_count = 0;
  int unsigned               responses_seen = 0;
  int unsigned               burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Apply one request to the shadow table and return what the block should report
  function automatic table_result_t apply_request(input table_request_t r);
    int            pos;
    bit            hit;
    table_result_t res;
    pos = model_count;
    hit = 1'b0;
    for (int i = 0; i < model_count; i++) begin
      if (!hit && model_keys[i] == r.key) begin
        pos = i;
        hit = 1'b1;
      end
    end
    res = '0;
    res.read_value = model_missing;
    case (r.req_type)
      REQ_INSERT: begin
        if (!hit) begin
          if (model_count >= CAPACITY) begin
            res.rejected = 1'b1;
          end else begin
            model_keys[model_count] = r.key;
            model_values[model_count] = r.value;
            model_count++;
          end
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          // Close the gap: move every later entry down one place
          for (int j = pos; j < model_count - 1; j++) begin
            model_keys[j] = model_keys[j + 1];
            model_values[j] = model_values[j + 1];
          end
          model_count--;
        end
      end
      default: begin
        if (hit) res.read_value = model_values[pos];
      end
    endcase
    res.found = hit;
    res.entry_count = model_count[COUNT_BITS-1:0];
    res.is_empty = (model_count == 0);
    res.is_full = (model_count == CAPACITY);
    return res;
  endfunction

  function automatic void add_row(input logic [REQ_TYPE_BITS-1:0] t,
                                  input logic [KEY_BITS_DEF-1:0] k,
                                  input logic [VALUE_BITS_DEF-1:0] v);
    directed_row_t row;
    row.req = '{req_type: t, key: k, value: v};
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(input logic [REQ_TYPE_BITS-1:0] t,
                                          input logic [KEY_BITS_DEF-1:0] k,
                                          input logic [VALUE_BITS_DEF-1:0] v,
                                          input logic f,
                                          input logic [RD_BITS-1:0] rv,
                                          input logic [COUNT_BITS-1:0] cnt,
                                          input logic emp,
                                          input logic full,
                                          input logic rej);
    directed_row_t row;
    row.req = '{req_type: t, key: k, value: v};
    row.typed = 1'b1;
    row.want = '{found: f, read_value: rv, entry_count: cnt, is_empty: emp,
                 is_full: full, rejected: rej};
    directed_rows.push_back(row);
  endfunction

  // Mix of operations set per phase; keys mostly from a small pool or the live table
  function automatic table_request_t random_request(input int unsigned ins_pct,
                                                    input int unsigned del_pct);
    table_request_t r;
    int unsigned    roll;
    int unsigned    pick;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) r.req_type = REQ_INSERT;
    else if (roll < ins_pct + del_pct) r.req_type = REQ_DELETE;
    else if (roll < 95) r.req_type = REQ_LOOKUP;
    else r.req_type = REQ_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick == 0) r.key = KEY_BITS_DEF'($urandom);
    else if (pick < 4 && model_count > 0) r.key = model_keys[$urandom_range(0, model_count - 1)];
    else r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.value = VALUE_BITS_DEF'($urandom);
    return r;
  endfunction

  task automatic write_missing(input logic [MISS_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    model_missing = v;
    cfg_we <= 1'b0;
  endtask

  // Hold the request until taken, then record what it should produce
  task automatic offer_request(input table_request_t r, input bit typed,
                               input table_result_t want);
    table_result_t predicted;
    req_bus.valid <= 1'b1;
    req_bus.req_type <= r.req_type;
    req_bus.key <= r.key;
    req_bus.value <= r.value;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = apply_request(r);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Send in bursts; drop valid for a random gap when a burst runs out
  task automatic idle_between_requests();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Check responses and drive ready on a pattern of stretches, with one long hold-off
  initial begin : response_side
    table_result_t want;
    int unsigned   hold_left;
    int unsigned   mode;
    int unsigned   mode_left;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("found", want.found, rsp_bus.found);
          compare_field("read_value", want.read_value, rsp_bus.read_value);
          compare_field("entry_count", want.entry_count, rsp_bus.entry_count);
          compare_field("is_empty", want.is_empty, rsp_bus.is_empty);
          compare_field("is_full", want.is_full, rsp_bus.is_full);
          compare_field("rejected", want.rejected, rsp_bus.rejected);
        end
        responses_seen++;
        if (responses_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 100);
        end
        mode_left--;
        case (mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    table_request_t       r;
    logic [MISS_BITS-1:0] miss;
    int unsigned          ins_pct;
    int unsigned          del_pct;
    int unsigned          guard;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_LOOKUP;
    req_bus.key <= '0;
    req_bus.value <= '0;

    // Directed rows: empty table, field extremes, special cases, fill and overflow
    add_checked_row(REQ_LOOKUP, 16'h0000, 16'h0000, 0, DIRECTED_MISS, 0, 1, 0, 0);
    add_checked_row(REQ_DELETE, 16'hFFFF, 16'h0000, 0, DIRECTED_MISS, 0, 1, 0, 0);
    add_checked_row(REQ_INSERT, 16'h0000, 16'hFFFF, 0, DIRECTED_MISS, 1, 0, 0, 0);
    add_checked_row(REQ_INSERT, 16'hFFFF, 16'h0000, 0, DIRECTED_MISS, 2, 0, 0, 0);
    add_checked_row(REQ_LOOKUP, 16'h0000, 16'h0000, 1, 16'hFFFF, 2, 0, 0, 0);
    add_checked_row(REQ_LOOKUP, 16'hFFFF, 16'hFFFF, 1, 16'h0000, 2, 0, 0, 0);
    add_checked_row(REQ_INSERT, 16'h0000, 16'h1234, 1, DIRECTED_MISS, 2, 0, 0, 0);
    add_checked_row(REQ_UNUSED, 16'hFFFF, 16'h0000, 1, 16'h0000, 2, 0, 0, 0);
    add_checked_row(REQ_DELETE, 16'h5555, 16'h0000, 0, DIRECTED_MISS, 2, 0, 0, 0);
    for (int i = 1; i <= CAPACITY - 2; i++) begin
      add_row(REQ_INSERT, 16'(16'h0111 * i), ~16'(16'h0111 * i));
    end
    add_checked_row(REQ_INSERT, 16'hAAAA, 16'h0001, 0, DIRECTED_MISS, 16, 0, 1, 1);
    add_checked_row(REQ_INSERT, 16'hFFFF, 16'h0001, 1, DIRECTED_MISS, 16, 0, 1, 0);
    add_checked_row(REQ_DELETE, 16'h0000, 16'h0000, 1, DIRECTED_MISS, 15, 0, 0, 0);
    add_checked_row(REQ_LOOKUP, 16'hFFFF, 16'h0000, 1, 16'h0000, 15, 0, 0, 0);
    add_row(REQ_DELETE, 16'h0EEE, 16'h0000);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_missing(DIRECTED_MISS);
    foreach (directed_rows[i]) begin
      idle_between_requests();
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    req_bus.valid <= 1'b0;

    // Random phases, each with its own missing value and operation mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      while (expected_results.size() != 0) @(posedge clk);
      case (p)
        0: begin miss = 16'h0000; ins_pct = 60; del_pct = 15; end
        1: begin miss = MISS_BITS'($urandom); ins_pct = 25; del_pct = 50; end
        2: begin miss = 16'hFFFF; ins_pct = 50; del_pct = 25; end
        3: begin miss = MISS_BITS'($urandom); ins_pct = 20; del_pct = 55; end
        default: begin miss = 16'h8001; ins_pct = 45; del_pct = 30; end
      endcase
      write_missing(miss);
      foreach (key_pool[i]) key_pool[i] = KEY_BITS_DEF'($urandom);
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        idle_between_requests();
        r = random_request(ins_pct, del_pct);
        offer_request(r, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
    end

    // Drain, then wait for anything stray before the final check
    guard = 0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d responses never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/skv_pkg.sv
design/skv_req_if.sv
design/skv_rsp_if.sv
design/skv_cell.sv
design/small_key_value_table.sv
design/skv_checker.sv
test/tb_top.sv
